// ----- src/snk_pkg.sv -----
// package: shared types, constants and coefficient function of the neighbourhood kernel
`default_nettype none
package snk_pkg;

  // fraction bits of the output weight
  localparam int FracBitsOut = 15;
  // quotient bits: 4 integer, 30 fraction
  localparam int QBits = 34;
  localparam int QFrac = 30;
  // exponential accumulator, unsigned Q1.33
  localparam int AccBits = 34;
  localparam int AccFrac = 33;
  // coefficient fraction bits
  localparam int CoefFrac = 31;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SHAPE_MODE    = 2'd0,
    REG_INITIAL_WIDTH = 2'd1,
    REG_TIME_CONSTANT = 2'd2
  } reg_idx_e;

  // side data that travels with a request
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] width;
  } snk_tag_t;

  // exp(-2^(3-i)) in Q0.31, rounded, worked out at elaboration
  function automatic logic [CoefFrac-1:0] exp_coef(input int i);
    real x;
    x = $exp(-(2.0 ** (3 - i))) * (2.0 ** CoefFrac) + 0.5;
    return CoefFrac'($rtoi(x));
  endfunction

endpackage
`default_nettype wire

// ----- src/snk_if.sv -----
// channel interfaces: input request, result and configuration write
`default_nettype none
interface snk_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] elapsed_time;
  logic [15:0] distance;
  modport source (output valid, output elapsed_time, output distance, input ready);
  modport sink (input valid, input elapsed_time, input distance, output ready);
endinterface

interface snk_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] neighborhood_value;
  logic [15:0] current_width;
  modport source (output valid, output neighborhood_value, output current_width, input ready);
  modport sink (input valid, input neighborhood_value, input current_width, output ready);
endinterface

interface snk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/snk_div.sv -----
// pipelined restoring divider: num/den as 4 integer and 30 fraction bits, one bit a stage
`default_nettype none
module snk_div
  import snk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ce_i,
  input  wire logic              valid_i,
  input  wire logic [31:0]       num_i,
  input  wire logic [32:0]       den_i,
  input  wire snk_tag_t          tag_i,
  output logic                   valid_o,
  output logic [QBits-1:0]       quot_o,
  output logic                   sat_o,
  output snk_tag_t               tag_o
);

  logic             vld_q [0:QBits];
  logic [32:0]      rem_q [0:QBits];
  logic [32:0]      den_q [0:QBits];
  logic [QBits-1:0] quo_q [0:QBits];
  logic [3:0]       lo_q  [0:QBits];
  logic             sat_q [0:QBits];
  snk_tag_t         tag_q [0:QBits];

  // entry stage: overflow check and first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ce_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0] <= {5'd0, num_i[31:4]};
      lo_q[0]  <= num_i[3:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= {5'd0, num_i} >= {den_i, 4'd0};
      tag_q[0] <= tag_i;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QBits; i++) begin : g_step
    logic        nb;
    logic [33:0] trial;
    logic        ge;
    logic [33:0] diff;

    if (i < 4) begin : g_lo
      assign nb = lo_q[i][3-i];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem_q[i], nb};
    assign ge    = trial >= {1'b0, den_q[i]};
    assign diff  = trial - {1'b0, den_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (ce_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[i+1] <= ge ? diff[32:0] : trial[32:0];
        quo_q[i+1] <= {quo_q[i][QBits-2:0], ge};
        lo_q[i+1]  <= lo_q[i];
        den_q[i+1] <= den_q[i];
        sat_q[i+1] <= sat_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = vld_q[QBits];
  assign quot_o  = quo_q[QBits];
  assign sat_o   = sat_q[QBits];
  assign tag_o   = tag_q[QBits];

endmodule
`default_nettype wire

// ----- src/snk_exp.sv -----
// pipelined exp(-x): one constant factor exp(-2^p) applied per quotient bit
`default_nettype none
module snk_exp
  import snk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ce_i,
  input  wire logic              valid_i,
  input  wire logic [QBits-1:0]  x_i,
  input  wire logic              sat_i,
  input  wire snk_tag_t          tag_i,
  output logic                   valid_o,
  output logic [AccBits-1:0]     acc_o,
  output snk_tag_t               tag_o
);

  logic               vld_q [0:QBits];
  logic [AccBits-1:0] acc_q [0:QBits];
  logic [QBits-1:0]   x_q   [0:QBits];
  logic               sat_q [0:QBits];
  snk_tag_t           tag_q [0:QBits];

  // entry stage: accumulator starts at one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ce_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      acc_q[0] <= AccBits'(1) << AccFrac;
      x_q[0]   <= x_i;
      sat_q[0] <= sat_i;
      tag_q[0] <= tag_i;
    end
  end

  // multiply by exp(-2^(3-i)) where bit is set, rounded to nearest
  for (genvar i = 0; i < QBits; i++) begin : g_step
    localparam logic [CoefFrac-1:0] Coef = exp_coef(i);
    logic [AccBits+CoefFrac-1:0] prod;
    logic [AccBits+CoefFrac-1:0] rnd;

    assign prod = acc_q[i] * Coef;
    assign rnd  = prod + ((AccBits+CoefFrac)'(1) << (CoefFrac-1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (ce_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        acc_q[i+1] <= x_q[i][QBits-1-i] ? rnd[CoefFrac +: AccBits] : acc_q[i];
        x_q[i+1]   <= x_q[i];
        sat_q[i+1] <= sat_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = vld_q[QBits];
  assign acc_o   = sat_q[QBits] ? '0 : acc_q[QBits];
  assign tag_o   = tag_q[QBits];

endmodule
`default_nettype wire

// ----- src/som_neighborhood_kernel.sv -----
// top level of the self-organising-map neighbourhood kernel
// Takes one request per cycle and returns one result per request, in order, through the
// pipeline registers: two chains of a 35-stage divider and a 35-stage exponential
// (one for the width decay, one for the gaussian), two stages for the width and the squares,
// and the output register. A stall on the result side holds the whole pipeline, so input
// ready follows output ready whenever a result is waiting. The width is
// initial_width*exp(-t/time_constant) in Q8.8; the weight is 1.0 or 0 in rectangular mode,
// exp(-d^2/(2w^2)) in Q1.15 in gaussian mode. Configuration writes are always taken and
// should only be made while no request is in flight.
`default_nettype none
module som_neighborhood_kernel
  import snk_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  snk_in_if.sink      in_i,
  snk_out_if.source   out_o,
  snk_cfg_if.sink     cfg_i
);

  localparam logic [15:0] One = 16'(1) << FracBitsOut;
  localparam int ValShift = AccFrac - FracBitsOut;

  logic        shape_q;
  logic [15:0] iw_q;
  logic [19:0] tc_q;
  logic        ce;
  logic        out_vld_q;
  logic [15:0] out_val_q;
  logic [15:0] out_w_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= 1'b0;
      iw_q    <= 16'd2560;
      tc_q    <= 20'd1000;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_SHAPE_MODE:    shape_q <= cfg_i.data[0];
        REG_INITIAL_WIDTH: iw_q    <= cfg_i.data[15:0];
        REG_TIME_CONSTANT: tc_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // global pipeline advance
  assign ce         = !out_vld_q || out_o.ready;
  assign in_i.ready = ce;

  // width decay: t / time_constant
  logic        d1_vld, d1_sat;
  logic [QBits-1:0] d1_q;
  snk_tag_t    d1_tag, in_tag;
  logic [32:0] tc_den;

  assign tc_den = (tc_q == '0) ? 33'd1 : {13'd0, tc_q};
  assign in_tag = '{distance: in_i.distance, width: 16'd0};

  snk_div u_div_t (
    .clk_i, .rst_ni, .ce_i(ce),
    .valid_i(in_i.valid), .num_i({12'd0, in_i.elapsed_time}), .den_i(tc_den),
    .tag_i(in_tag), .valid_o(d1_vld), .quot_o(d1_q), .sat_o(d1_sat), .tag_o(d1_tag)
  );

  logic               e1_vld;
  logic [AccBits-1:0] e1_acc;
  snk_tag_t           e1_tag;

  snk_exp u_exp_t (
    .clk_i, .rst_ni, .ce_i(ce),
    .valid_i(d1_vld), .x_i(d1_q), .sat_i(d1_sat), .tag_i(d1_tag),
    .valid_o(e1_vld), .acc_o(e1_acc), .tag_o(e1_tag)
  );

  // width stage: round(initial_width * exp)
  logic        w_vld_q;
  snk_tag_t    w_tag_q;
  logic [AccBits+15:0] w_prod;

  assign w_prod = iw_q * e1_acc + ((AccBits+16)'(1) << (AccFrac-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
    end else if (ce) begin
      w_vld_q <= e1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      w_tag_q <= '{distance: e1_tag.distance, width: w_prod[AccFrac +: 16]};
    end
  end

  // squares: d^2 and 2w^2
  logic        m_vld_q;
  snk_tag_t    m_tag_q;
  logic [31:0] m_num_q;
  logic [32:0] m_den_q;
  logic [31:0] w_sq;

  assign w_sq = w_tag_q.width * w_tag_q.width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (ce) begin
      m_vld_q <= w_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      m_tag_q <= w_tag_q;
      m_num_q <= w_tag_q.distance * w_tag_q.distance;
      m_den_q <= (w_tag_q.width == '0) ? 33'd1 : {w_sq, 1'b0};
    end
  end

  // gaussian exponent: d^2 / (2w^2)
  logic        d2_vld, d2_sat;
  logic [QBits-1:0] d2_q;
  snk_tag_t    d2_tag;

  snk_div u_div_g (
    .clk_i, .rst_ni, .ce_i(ce),
    .valid_i(m_vld_q), .num_i(m_num_q), .den_i(m_den_q), .tag_i(m_tag_q),
    .valid_o(d2_vld), .quot_o(d2_q), .sat_o(d2_sat), .tag_o(d2_tag)
  );

  logic               e2_vld;
  logic [AccBits-1:0] e2_acc;
  snk_tag_t           e2_tag;

  snk_exp u_exp_g (
    .clk_i, .rst_ni, .ce_i(ce),
    .valid_i(d2_vld), .x_i(d2_q), .sat_i(d2_sat), .tag_i(d2_tag),
    .valid_o(e2_vld), .acc_o(e2_acc), .tag_o(e2_tag)
  );

  // weight selection into the output register
  logic [AccBits-1:0] g_rnd;
  logic [15:0]        val_d;

  assign g_rnd = e2_acc + (AccBits'(1) << (ValShift-1));

  always_comb begin
    if (!shape_q) begin
      val_d = (e2_tag.distance < e2_tag.width) ? One : 16'd0;
    end else if (e2_tag.width == '0) begin
      val_d = (e2_tag.distance == '0) ? One : 16'd0;
    end else begin
      val_d = 16'(g_rnd >> ValShift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ce) begin
      out_vld_q <= e2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_val_q <= val_d;
      out_w_q   <= e2_tag.width;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.neighborhood_value = out_val_q;
  assign out_o.current_width      = out_w_q;

`ifndef SYNTH
  // rectangular weight is either one or zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !shape_q) |-> (out_val_q == One || out_val_q == 16'd0))
    else $error("rectangular weight not binary");
  // decayed width never exceeds the initial width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_w_q <= iw_q))
    else $error("width above initial width");
  // weight never above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_val_q <= One))
    else $error("weight above one");
  // a waiting result stalls the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken during output stall");
`endif

endmodule
`default_nettype wire

// ----- dv/som_neighborhood_kernel_tb.sv -----
// testbench of the som neighbourhood kernel: directed and random requests checked against a predictor
module som_neighborhood_kernel_tb;
  import snk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] Q62One = 64'h4000_0000_0000_0000;
  localparam int TailCycles = 140;

  // weight predictor and store of expected results
  class weight_ledger;
    typedef struct {
      logic [15:0] weight;
      logic [15:0] width;
      bit          gauss;
    } weight_exp_t;

    bit          shape_gauss;
    logic [15:0] width0;
    logic [19:0] decay_tc;
    weight_exp_t pending_weights[$];
    int          mismatches;
    logic [63:0] inv_e;

    function new();
      shape_gauss = 1'b0;
      width0      = 16'd2560;
      decay_tc    = 20'd1000;
      mismatches  = 0;
      inv_e       = exp_frac(Q62One);
    endfunction

    // rounded product shifted down by s
    function logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (s - 1));
      return 64'(p >> s);
    endfunction

    // exp(-f), f in q0.62, series in q2.62
    function logic [63:0] exp_frac(logic [63:0] f);
      logic [63:0] pos, neg, term;
      pos = Q62One;
      neg = 64'd0;
      term = Q62One;
      for (int n = 1; n <= 24; n++) begin
        term = mul_rnd(term, f, 62) / n;
        if (n % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      return pos - neg;
    endfunction

    function logic [63:0] exp_whole(logic [63:0] k, logic [63:0] f);
      logic [63:0] r;
      if (k >= 64) return 64'd0;
      r = exp_frac(f);
      for (int i = 0; i < k; i++) r = mul_rnd(r, inv_e, 62);
      return r;
    endfunction

    // integer part and truncated q0.62 fraction of num / den
    function void split_quot(logic [63:0] num, logic [63:0] den,
                             output logic [63:0] k, output logic [63:0] f);
      logic [63:0] rem;
      rem = num % den;
      k = num / den;
      f = 64'd0;
      for (int i = 0; i < 62; i++) begin
        rem = rem << 1;
        f = f << 1;
        if (rem >= den) begin
          rem = rem - den;
          f[0] = 1'b1;
        end
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        REG_SHAPE_MODE:    shape_gauss = data[0];
        REG_INITIAL_WIDTH: width0 = data[15:0];
        REG_TIME_CONSTANT: decay_tc = data;
        default: ;
      endcase
    endfunction

    // predict the result of one accepted request
    function void note_request(logic [19:0] t, logic [15:0] d);
      logic [63:0] k, f, e, w, tc, one;
      weight_exp_t x;
      tc = (decay_tc == 0) ? 64'd1 : 64'(decay_tc);
      one = 64'd1 << FracBitsOut;
      split_quot(64'(t), tc, k, f);
      e = exp_whole(k, f);
      w = mul_rnd(64'(width0), e, 62) & 64'hFFFF;
      x.gauss = shape_gauss;
      if (!shape_gauss) x.weight = (64'(d) < w) ? one[15:0] : 16'd0;
      else if (w == 0) x.weight = (d == 0) ? one[15:0] : 16'd0;
      else begin
        split_quot(64'(d) * 64'(d), 64'd2 * w * w, k, f);
        e = exp_whole(k, f);
        x.weight = 16'(mul_rnd(e, one, 62));
      end
      x.width = w[15:0];
      pending_weights.push_back(x);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(logic [15:0] weight, logic [15:0] width);
      weight_exp_t x;
      bit bad;
      int diff;
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result weight=%0d width=%0d", weight, width);
        return;
      end
      x = pending_weights.pop_front();
      diff = int'(weight) - int'(x.weight);
      bad = (width !== x.width);
      if (x.gauss) bad = bad || $isunknown(weight) || diff > 1 || diff < -1;
      else bad = bad || (weight !== x.weight);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch weight exp=%0d act=%0d width exp=%0d act=%0d",
                   x.weight, weight, x.width, width);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  snk_in_if  in_bus();
  snk_out_if out_bus();
  snk_cfg_if cfg_bus();
  weight_ledger ledger;

  som_neighborhood_kernel dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // monitor of all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) ledger.write_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) ledger.note_request(in_bus.elapsed_time, in_bus.distance);
      if (out_bus.valid && out_bus.ready)
        ledger.check_result(out_bus.neighborhood_value, out_bus.current_width);
    end
  end

  // result side: runs of ready with random stalls
  initial begin
    int n;
    out_bus.ready <= 1'b0;
    forever begin
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      n = idle_len();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // one request, then a random gap
  task automatic send_request(logic [19:0] t, logic [15:0] d);
    int n;
    in_bus.valid <= 1'b1;
    in_bus.elapsed_time <= t;
    in_bus.distance <= d;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    n = idle_len();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [19:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // wait until all results are back and the pipeline is empty
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending_weights.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_shape(bit gauss, logic [15:0] w0, logic [19:0] tc);
    cfg_write(REG_SHAPE_MODE, {19'd0, gauss});
    cfg_write(REG_INITIAL_WIDTH, {4'd0, w0});
    cfg_write(REG_TIME_CONSTANT, tc);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random requests biased towards the interesting range of t and d
  task automatic random_requests(int count, logic [15:0] w0, logic [19:0] tc);
    logic [19:0] t;
    logic [15:0] d;
    int tmax, dmax;
    tmax = (int'(tc) * 6 > 20'hFFFFF) ? 20'hFFFFF : int'(tc) * 6;
    dmax = (int'(w0) * 2 + 2 > 16'hFFFF) ? 16'hFFFF : int'(w0) * 2 + 2;
    for (int i = 0; i < count; i++) begin
      t = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, tmax));
      d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, dmax));
      send_request(t, d);
      if (i == count / 2 && $urandom_range(0, 1) == 1) begin
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
        while (ledger.pending_weights.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  // stimulus
  initial begin
    logic [15:0] rw;
    logic [19:0] rt;
    ledger = new();
    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.elapsed_time <= '0;
    in_bus.distance <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_SHAPE_MODE;
    cfg_bus.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings, rectangular edges
    send_request(20'd0, 16'd0);
    send_request(20'd0, 16'd2559);
    send_request(20'd0, 16'd2560);
    send_request(20'd1000, 16'hFFFF);
    send_request(20'hFFFFF, 16'd0);
    random_requests(50, 16'd2560, 20'd1000);
    drain();

    // gaussian, zero distance, huge exponent and zero width
    set_shape(1'b1, 16'd2560, 20'd1000);
    send_request(20'd0, 16'd0);
    send_request(20'd0, 16'hFFFF);
    send_request(20'd0, 16'd2560);
    send_request(20'd100000, 16'd0);
    send_request(20'd100000, 16'd1);
    send_request(20'hFFFFF, 16'hFFFF);
    random_requests(50, 16'd2560, 20'd1000);
    drain();

    set_shape(1'b1, 16'hFFFF, 20'd1);
    send_request(20'd0, 16'hFFFF);
    send_request(20'd63, 16'd0);
    send_request(20'd64, 16'd0);
    random_requests(50, 16'hFFFF, 20'd1);
    drain();

    set_shape(1'b0, 16'hFFFF, 20'hFFFFF);
    send_request(20'hFFFFF, 16'hFFFF);
    send_request(20'd0, 16'hFFFE);
    random_requests(50, 16'hFFFF, 20'hFFFFF);
    drain();

    // zero width in both shapes
    set_shape(1'b1, 16'd0, 20'd500);
    send_request(20'd0, 16'd0);
    send_request(20'd0, 16'd1);
    random_requests(20, 16'd0, 20'd500);
    drain();
    set_shape(1'b0, 16'd0, 20'd500);
    send_request(20'd0, 16'd0);
    random_requests(20, 16'd0, 20'd500);
    drain();

    // random settings
    for (int p = 0; p < 4; p++) begin
      rw = 16'($urandom);
      rt = 20'($urandom_range(1, 20'hFFFFF));
      if ($urandom_range(0, 1) == 1) rt = 20'($urandom_range(1, 5000));
      set_shape(p[0], rw, rt);
      random_requests(45, rw, rt);
      drain();
    end

    set_shape(1'b1, 16'hFFFF, 20'hFFFFF);
    random_requests(40, 16'hFFFF, 20'hFFFFF);
    drain();

    if (ledger.mismatches == 0 && ledger.pending_weights.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
